### rtl/rlepd_pkg.sv
// ============================================================================
// rlepd_pkg: shared types and constants of the RLE pixel decoder
// Widths of the stream fields, decoder phases, register indexes and the
// command word that travels from the parser to the result emitter.
// ============================================================================
package rlepd_pkg;

	// Field widths fixed by the stream format.
	localparam int CNT_W   = 15;   // pixel counts and pixel_total
	localparam int LEN_W   = 16;   // byte counts and stream_length
	localparam int PIXEL_W = 16;   // one RGB565 pixel
	localparam int ITEMS_W = 9;    // pixels named by one header, up to 128
	localparam int NEED_W  = 10;   // payload bytes named by one header
	localparam int CFG_W   = 16;   // widest configuration register

	// Clamps applied to the configured image size and stream length.
	localparam int MAX_PIXELS       = 16384;
	localparam int MAX_STREAM_BYTES = 65535;

	// Reset values of the configuration registers.
	localparam int PIXEL_TOTAL_RST   = 5184;
	localparam int STREAM_LENGTH_RST = 1;

	// Default depth of the command queue.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_PIXEL_TOTAL   = 1'b0,
		REG_STREAM_LENGTH = 1'b1
	} reg_index_t;

	// Parser phase: waiting for a header, the high or the low pixel byte.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_HIGH   = 2'd1,
		PH_LOW    = 2'd2
	} phase_t;

	// One parser command: a first result and an optional black fill after it.
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [CNT_W-1:0]   count;
		logic               last;
		logic               error;
		logic               has_fill;
		logic [CNT_W-1:0]   fill_count;
	} cmd_t;

endpackage

### rtl/rlepd_front.sv
// ============================================================================
// rlepd_front: byte parser of the RLE pixel decoder
// Holds the configuration and decode state, takes one byte per cycle while the
// queue has room, and turns each byte that causes results into one command.
// ============================================================================
module rlepd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [0:0]                    wr_index,
	input  logic [rlepd_pkg::CFG_W-1:0]   wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    code_byte,
	input  logic                          q_full,
	output logic                          push,
	output rlepd_pkg::cmd_t               cmd
);

	logic [rlepd_pkg::CNT_W-1:0]   pixel_total_q;
	logic [rlepd_pkg::LEN_W-1:0]   stream_length_q;

	logic [rlepd_pkg::LEN_W-1:0]   bytes_seen_q, bytes_seen_d;
	logic [rlepd_pkg::CNT_W-1:0]   pixels_written_q, pixels_written_d;
	rlepd_pkg::phase_t             phase_q, phase_d;
	logic                          is_run_q, is_run_d;
	logic [rlepd_pkg::ITEMS_W-1:0] items_left_q, items_left_d;
	logic [7:0]                    high_byte_q, high_byte_d;
	logic                          image_done_q, image_done_d;

	logic                          accept;
	logic [rlepd_pkg::CNT_W-1:0]   total;
	logic [rlepd_pkg::LEN_W-1:0]   len;
	logic                          nothing_owed;
	logic                          stream_used;
	logic [rlepd_pkg::CNT_W-1:0]   owed;
	logic [rlepd_pkg::LEN_W-1:0]   bytes_inc;
	logic [rlepd_pkg::CNT_W-1:0]   items_ext;
	logic [rlepd_pkg::CNT_W-1:0]   pix_cnt;
	logic [rlepd_pkg::CNT_W-1:0]   rest;
	logic                          pix_done;
	logic [rlepd_pkg::ITEMS_W-1:0] items_after;
	logic                          at_boundary_end;
	logic                          hdr_run;
	logic [rlepd_pkg::ITEMS_W-1:0] hdr_items;
	logic [rlepd_pkg::NEED_W-1:0]  hdr_need;
	logic                          hdr_fail;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Effective limits after clamping.
	assign total = (32'(pixel_total_q) < rlepd_pkg::MAX_PIXELS) ? pixel_total_q
		: rlepd_pkg::CNT_W'(rlepd_pkg::MAX_PIXELS);
	assign len = (32'(stream_length_q) < rlepd_pkg::MAX_STREAM_BYTES) ? stream_length_q
		: rlepd_pkg::LEN_W'(rlepd_pkg::MAX_STREAM_BYTES);

	assign nothing_owed = pixels_written_q >= total;
	assign stream_used  = bytes_seen_q >= len;
	assign owed         = total - pixels_written_q;
	assign bytes_inc    = bytes_seen_q + 1'b1;

	// Pixel completion: a run takes the clipped repeat, a literal one pixel.
	assign items_ext = rlepd_pkg::CNT_W'(items_left_q);
	assign pix_cnt   = is_run_q ? ((items_ext < owed) ? items_ext : owed)
		: rlepd_pkg::CNT_W'(1);
	assign pix_done  = pix_cnt == owed;
	assign rest      = owed - pix_cnt;
	assign items_after = is_run_q ? '0
		: ((items_left_q != '0) ? items_left_q - 1'b1 : '0);
	assign at_boundary_end = (items_after == '0) && (bytes_inc >= len);

	// Header decode and payload check against the stream length.
	assign hdr_run   = code_byte[7];
	assign hdr_items = hdr_run ? rlepd_pkg::ITEMS_W'(code_byte[6:0]) + 1'b1
		: rlepd_pkg::ITEMS_W'(code_byte) + 1'b1;
	assign hdr_need  = hdr_run ? rlepd_pkg::NEED_W'(2) : {hdr_items, 1'b0};
	assign hdr_fail  = ((rlepd_pkg::LEN_W+1)'(bytes_inc) + (rlepd_pkg::LEN_W+1)'(hdr_need))
		> (rlepd_pkg::LEN_W+1)'(len);

	// Next state.
	always_comb begin
		bytes_seen_d     = bytes_seen_q;
		pixels_written_d = pixels_written_q;
		phase_d          = phase_q;
		is_run_d         = is_run_q;
		items_left_d     = items_left_q;
		high_byte_d      = high_byte_q;
		image_done_d     = image_done_q;
		if (accept && !image_done_q) begin
			if (nothing_owed) begin
				image_done_d = 1'b1;
			end else if (stream_used) begin
				image_done_d = 1'b1;
			end else begin
				bytes_seen_d = bytes_inc;
				case (phase_q)
					rlepd_pkg::PH_HIGH: begin
						high_byte_d = code_byte;
						phase_d     = rlepd_pkg::PH_LOW;
					end
					rlepd_pkg::PH_LOW: begin
						pixels_written_d = pixels_written_q + pix_cnt;
						items_left_d     = items_after;
						if (pix_done) begin
							image_done_d = 1'b1;
						end else begin
							phase_d = (items_after == '0) ? rlepd_pkg::PH_HEADER
								: rlepd_pkg::PH_HIGH;
							if (at_boundary_end) begin
								image_done_d = 1'b1;
							end
						end
					end
					default: begin
						is_run_d     = hdr_run;
						items_left_d = hdr_items;
						if (hdr_fail) begin
							image_done_d = 1'b1;
						end else begin
							phase_d = rlepd_pkg::PH_HIGH;
						end
					end
				endcase
			end
		end
	end

	// Command output.
	always_comb begin
		push           = 1'b0;
		cmd.pixel      = '0;
		cmd.count      = '0;
		cmd.last       = 1'b0;
		cmd.error      = 1'b0;
		cmd.has_fill   = 1'b0;
		cmd.fill_count = '0;
		if (accept && !image_done_q && !nothing_owed) begin
			if (stream_used) begin
				push     = 1'b1;
				cmd.last = 1'b1;
				if (phase_q == rlepd_pkg::PH_HIGH || phase_q == rlepd_pkg::PH_LOW) begin
					cmd.error = 1'b1;
				end else begin
					cmd.count = owed;
				end
			end else begin
				case (phase_q)
					rlepd_pkg::PH_HIGH: begin
						push = 1'b0;
					end
					rlepd_pkg::PH_LOW: begin
						push      = 1'b1;
						cmd.pixel = {high_byte_q, code_byte};
						cmd.count = pix_cnt;
						cmd.last  = pix_done;
						if (!pix_done && at_boundary_end) begin
							cmd.has_fill   = 1'b1;
							cmd.fill_count = rest;
						end
					end
					default: begin
						if (hdr_fail) begin
							push      = 1'b1;
							cmd.last  = 1'b1;
							cmd.error = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q    <= rlepd_pkg::CNT_W'(rlepd_pkg::PIXEL_TOTAL_RST);
			stream_length_q  <= rlepd_pkg::LEN_W'(rlepd_pkg::STREAM_LENGTH_RST);
			bytes_seen_q     <= '0;
			pixels_written_q <= '0;
			phase_q          <= rlepd_pkg::PH_HEADER;
			is_run_q         <= 1'b0;
			items_left_q     <= '0;
			high_byte_q      <= '0;
			image_done_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				case (rlepd_pkg::reg_index_t'(wr_index))
					rlepd_pkg::REG_PIXEL_TOTAL:   pixel_total_q   <= wr_data[rlepd_pkg::CNT_W-1:0];
					rlepd_pkg::REG_STREAM_LENGTH: stream_length_q <= wr_data[rlepd_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			bytes_seen_q     <= bytes_seen_d;
			pixels_written_q <= pixels_written_d;
			phase_q          <= phase_d;
			is_run_q         <= is_run_d;
			items_left_q     <= items_left_d;
			high_byte_q      <= high_byte_d;
			image_done_q     <= image_done_d;
		end
	end

endmodule

### rtl/rlepd_queue.sv
// ============================================================================
// rlepd_queue: command queue of the RLE pixel decoder
// A small first-in first-out buffer between the parser and the emitter.
// ============================================================================
module rlepd_queue #(
	parameter int DEPTH = rlepd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rlepd_pkg::cmd_t push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output rlepd_pkg::cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rlepd_pkg::cmd_t    entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head_cmd  = entries_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/rlepd_back.sv
// ============================================================================
// rlepd_back: result emitter of the RLE pixel decoder
// Pops commands and drives the registered result channel, one beat per cycle
// while ready, with a trailing black fill beat where a command asks for one.
// ============================================================================
module rlepd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  rlepd_pkg::cmd_t               q_cmd,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rlepd_pkg::PIXEL_W-1:0] pixel_value,
	output logic [rlepd_pkg::CNT_W-1:0]   repeat_count,
	output logic                          image_end,
	output logic                          error_flag
);

	logic                          out_valid_q;
	logic [rlepd_pkg::PIXEL_W-1:0] pixel_q;
	logic [rlepd_pkg::CNT_W-1:0]   count_q;
	logic                          last_q;
	logic                          error_q;
	logic                          fill_pending_q;
	logic [rlepd_pkg::CNT_W-1:0]   fill_count_q;
	logic                          load;

	// The output register can take a new beat when empty or being drained.
	assign load  = !out_valid_q || out_ready;
	assign q_pop = load && !fill_pending_q && q_not_empty;

	assign out_valid    = out_valid_q;
	assign pixel_value  = pixel_q;
	assign repeat_count = count_q;
	assign image_end    = last_q;
	assign error_flag   = error_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (fill_pending_q) begin
				pixel_q <= '0;
				count_q <= fill_count_q;
				last_q  <= 1'b1;
				error_q <= 1'b0;
			end else begin
				pixel_q      <= q_cmd.pixel;
				count_q      <= q_cmd.count;
				last_q       <= q_cmd.last;
				error_q      <= q_cmd.error;
				fill_count_q <= q_cmd.fill_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			fill_pending_q <= 1'b0;
		end else if (load) begin
			if (fill_pending_q) begin
				out_valid_q    <= 1'b1;
				fill_pending_q <= 1'b0;
			end else begin
				out_valid_q    <= q_not_empty;
				fill_pending_q <= q_not_empty && q_cmd.has_fill;
			end
		end
	end

endmodule

### rtl/rle_pixel_decoder.sv
// ============================================================================
// rle_pixel_decoder: run-length decoder for 16-bit pixel image streams
// Parses compressed bytes into pixels with repeat counts, fills a short
// stream with black and flags headers whose payload overruns the stream.
// ============================================================================
// Path: a result beat is written into the command queue and then into the
// emitter's output register, when the output channel is free.
// Throughput: one byte per cycle in while the queue is not full; one result
// beat per cycle out while out_ready is high. A byte that causes a pixel and
// a fill gives two emitter beats; the queue absorbs that so input flows on.
// Reset: asynchronous; clears decode state, empties the queue and the output
// register, and returns pixel_total to 5184 and stream_length to 1.
module rle_pixel_decoder #(
	parameter int QUEUE_DEPTH = rlepd_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration writes: index 0 is pixel_total, index 1 is stream_length.
	input  logic                          wr_en,
	input  logic [0:0]                    wr_index,
	input  logic [rlepd_pkg::CFG_W-1:0]   wr_data,
	// Compressed byte channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    code_byte,
	// Decoded result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rlepd_pkg::PIXEL_W-1:0] pixel_value,
	output logic [rlepd_pkg::CNT_W-1:0]   repeat_count,
	output logic                          image_end,
	output logic                          error_flag
);

	// Commands cross from the parser to the emitter through the queue, so a
	// stalled output only holds off input once the queue has filled up.
	logic            q_push;
	rlepd_pkg::cmd_t q_push_cmd;
	logic            q_pop;
	logic            q_full;
	logic            q_not_empty;
	rlepd_pkg::cmd_t q_head_cmd;

	// The parser decides every outcome of a byte in the cycle it is taken:
	// header decode with the payload check, pixel assembly, clipping of the
	// repeat count to the pixels still owed, and the end-of-image cases.
	rlepd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_byte (code_byte),
		.q_full    (q_full),
		.push      (q_push),
		.cmd       (q_push_cmd)
	);

	rlepd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_cmd  (q_head_cmd)
	);

	// The emitter owns the registered output beat and splits a command with
	// a trailing fill into two beats.
	rlepd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_cmd        (q_head_cmd),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_end    (image_end),
		.error_flag   (error_flag)
	);

endmodule

### verif/rle_pixel_decoder_tb.sv
// ----------------------------------------------------------------------------
// rle_pixel_decoder_tb: self-checking bench for the RLE pixel decoder
// Streams one compressed image through the byte channel and decodes every
// accepted byte in a local model of the parser. Each result beat is checked
// against the oldest predicted beat. The image ends in one of several
// randomly chosen ways: filled, short stream, payload overrun, nothing owed,
// or stream used up.
// ----------------------------------------------------------------------------
module rle_pixel_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rlepd_pkg::*;

	// A header byte with this bit set announces a run of one pixel value.
	localparam logic [7:0] RUN_FLAG = 8'h80;
	// Pixels the random stream may draw before the ending. Every pixel_total
	// written before the ending sits above this, so the image stays open.
	localparam int PIXEL_BUDGET = 14000;
	localparam int TOTAL_FLOOR = 14500;
	// Cycles to wait once nothing is expected. A byte with no result may
	// still sit in the parser or the command queue.
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int TIMEOUT_NS = 2_000_000;

	// The ways the single image of the run is brought to its end.
	typedef enum int {
		END_FULL,
		END_SHORT_STREAM,
		END_OVERRUN,
		END_NOTHING_OWED,
		END_USED_UP_HEADER,
		END_USED_UP_ITEM
	} ending_t;

	// One predicted result beat.
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [CNT_W-1:0]   count;
		logic               last;
		logic               err;
	} pixel_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [0:0]         wr_index = REG_PIXEL_TOTAL;
	logic [CFG_W-1:0]   wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         code_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PIXEL_W-1:0] pixel_value;
	logic [CNT_W-1:0]   repeat_count;
	logic               image_end;
	logic               error_flag;

	rle_pixel_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_byte    (code_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_end    (image_end),
		.error_flag   (error_flag)
	);

	// Bytes waiting for the driver, and result beats waiting for the DUT.
	logic [7:0]  pending_bytes[$];
	pixel_beat_t pixel_beats_due[$];

	// Local copy of the configuration, as the DUT holds it after reset.
	logic [CNT_W-1:0] px_total_cfg = CNT_W'(PIXEL_TOTAL_RST);
	logic [LEN_W-1:0] stream_len_cfg = LEN_W'(STREAM_LENGTH_RST);

	// Local copy of the parser state.
	logic [LEN_W-1:0] seen_bytes = '0;
	logic [CNT_W-1:0] drawn_px = '0;
	phase_t           dec_phase = PH_HEADER;
	logic             run_mode = 1'b0;
	logic [7:0]       left_items = '0;
	logic [7:0]       hi_byte = '0;
	logic             img_done = 1'b0;

	// Set for stretches in which neither side idles at random; always set for the ending.
	logic quiet_mode = 1'b0;

	int unsigned mismatches = 0;
	int unsigned beats_checked = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	function automatic void expect_beat(input int pix, input int cnt, input bit last,
			input bit err);
		pixel_beat_t b;
		b.pixel = PIXEL_W'(pix);
		b.count = CNT_W'(cnt);
		b.last  = last;
		b.err   = err;
		pixel_beats_due.push_back(b);
	endfunction

	// Decodes one accepted byte and queues the result beats it causes.
	task automatic decode_byte(input logic [7:0] b);
		int total, len, owed, need, cnt;
		logic [PIXEL_W-1:0] pix;
		total = (px_total_cfg < MAX_PIXELS) ? int'(px_total_cfg) : MAX_PIXELS;
		len = (stream_len_cfg < MAX_STREAM_BYTES) ? int'(stream_len_cfg) : MAX_STREAM_BYTES;
		// Once the image is finished, everything up to reset is swallowed.
		if (img_done)
			return;
		// The total may have been lowered to or below what is already drawn.
		if (drawn_px >= total) begin
			img_done = 1'b1;
			return;
		end
		// The stream may already be used up when this byte shows up: between
		// items the rest of the image is filled black, inside one it is an error.
		if (seen_bytes >= len) begin
			if (dec_phase == PH_HIGH || dec_phase == PH_LOW)
				expect_beat(0, 0, 1'b1, 1'b1);
			else
				expect_beat(0, total - int'(drawn_px), 1'b1, 1'b0);
			img_done = 1'b1;
			return;
		end
		seen_bytes++;
		case (dec_phase)
			PH_HIGH: begin
				hi_byte = b;
				dec_phase = PH_LOW;
			end
			PH_LOW: begin
				pix = {hi_byte, b};
				owed = total - int'(drawn_px);
				if (run_mode) begin
					// A run is clipped to the pixels still owed.
					cnt = (left_items < owed) ? int'(left_items) : owed;
					left_items = '0;
				end else begin
					cnt = 1;
					if (left_items > 0)
						left_items--;
				end
				drawn_px += CNT_W'(cnt);
				if (drawn_px >= total) begin
					expect_beat(pix, cnt, 1'b1, 1'b0);
					img_done = 1'b1;
				end else begin
					expect_beat(pix, cnt, 1'b0, 1'b0);
					dec_phase = (left_items == 0) ? PH_HEADER : PH_HIGH;
					// The item ended on the last stream byte with pixels still
					// owed, so a black fill follows in the same step.
					if (dec_phase == PH_HEADER && seen_bytes >= len) begin
						expect_beat(0, total - int'(drawn_px), 1'b1, 1'b0);
						img_done = 1'b1;
					end
				end
			end
			default: begin
				run_mode = b[7];
				if (b[7]) begin
					left_items = {1'b0, b[6:0]} + 8'd1;
					need = 2;
				end else begin
					left_items = b + 8'd1;
					need = 2 * (int'(b) + 1);
				end
				// The whole payload must fit, even where fewer pixels are owed.
				if (int'(seen_bytes) + need > len) begin
					expect_beat(0, 0, 1'b1, 1'b1);
					img_done = 1'b1;
				end else begin
					dec_phase = PH_HIGH;
				end
			end
		endcase
	endtask

	// Register write: drive on one edge, sampled by the DUT on the next.
	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_PIXEL_TOTAL)
			px_total_cfg = value[CNT_W-1:0];
		else
			stream_len_cfg = value;
	endtask

	task automatic queue_run(input int reps, input logic [PIXEL_W-1:0] pix);
		pending_bytes.push_back(RUN_FLAG | 8'(reps - 1));
		pending_bytes.push_back(pix[15:8]);
		pending_bytes.push_back(pix[7:0]);
	endtask

	task automatic queue_literal(input int n);
		logic [PIXEL_W-1:0] pix;
		pending_bytes.push_back(8'(n - 1));
		repeat (n) begin
			pix = PIXEL_W'($urandom);
			pending_bytes.push_back(pix[15:8]);
			pending_bytes.push_back(pix[7:0]);
		end
	endtask

	// Well-formed items with random content: mostly runs and short literal
	// groups, now and then a full 128-pixel run or a long literal group. The
	// pixel budget keeps the image open until the ending is chosen.
	task automatic queue_random_items(input int nbytes);
		int room, used, reps, n;
		room = PIXEL_BUDGET - int'(drawn_px);
		used = 0;
		while (used < nbytes && room > 0) begin
			if ($urandom_range(0, 9) < 6) begin
				reps = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(1, 64);
				if (reps > room)
					reps = room;
				queue_run(reps, PIXEL_W'($urandom));
				used += 3;
				room -= reps;
			end else begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 128)
					: $urandom_range(1, 6);
				if (n > room)
					n = room;
				queue_literal(n);
				used += 1 + 2 * n;
				room -= n;
			end
		end
	endtask

	// Waits until every queued byte is in and every predicted beat is out,
	// then gives bytes without a result time to leave the pipeline.
	task automatic drain_and_wait(input int extra);
		while (pending_bytes.size() != 0 || in_valid || pixel_beats_due.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Byte driver. The byte accepted at this edge is decoded by the model
	// first; then the next byte is offered, unless an idle burst is running.
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(code_byte);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					in_valid <= 1'b1;
					code_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver. Besides short random stalls it twice holds ready low
	// for a long stretch, so the command queue fills and in_ready drops while
	// the driver keeps offering bytes.
	int stall_left = 0;
	int hold_left = 0;
	int ready_beats = 0;
	int next_hold_at = 40;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				ready_beats++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (ready_beats >= next_hold_at) begin
				hold_left = HOLD_CYCLES - 1;
				next_hold_at = (next_hold_at == 40) ? 200 : 32'h7fff_ffff;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Checker: every result beat is matched against the oldest prediction.
	pixel_beat_t want;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pixel_beats_due.size() == 0) begin
				report_mismatch($sformatf("beat %0d: unexpected, pixel %h count %0d end %b err %b",
					beats_checked, pixel_value, repeat_count, image_end, error_flag));
			end else begin
				want = pixel_beats_due.pop_front();
				if (pixel_value !== want.pixel || repeat_count !== want.count
						|| image_end !== want.last || error_flag !== want.err)
					report_mismatch($sformatf(
						"beat %0d: got pixel %h count %0d end %b err %b, predicted %h %0d %b %b",
						beats_checked, pixel_value, repeat_count, image_end, error_flag,
						want.pixel, want.count, want.last, want.err));
			end
			beats_checked++;
		end
	end

	// Stimulus. Reset happens once, so the whole run is one image: the
	// directed items, several random chunks under changing settings, and
	// one randomly chosen way of ending the image, after which trailing
	// bytes must be swallowed without a result.
	initial begin
		ending_t ending;
		int k, n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Both registers at their widest value. Bit 15 of the pixel total is
		// dropped by the register and the value is clamped to MAX_PIXELS.
		write_reg(REG_PIXEL_TOTAL, 16'hFFFF);
		write_reg(REG_STREAM_LENGTH, 16'hFFFF);

		// Directed items: shortest and longest runs on black and white, a
		// single literal pixel, and a literal group with edge bit patterns.
		queue_run(1, 16'h0000);
		queue_run(128, 16'hFFFF);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hA5);
		pending_bytes.push_back(8'h5A);
		pending_bytes.push_back(8'h02);
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'h01);
		pending_bytes.push_back(8'h7F);
		pending_bytes.push_back(8'hFE);
		pending_bytes.push_back(8'h12);
		pending_bytes.push_back(8'h34);
		queue_run(6, 16'h5AA5);
		drain_and_wait(SETTLE_CYCLES);

		// Random chunks, each under a fresh pair of settings that keep the
		// image open. Every other chunk runs without idling.
		for (int c = 0; c < 8; c++) begin
			write_reg(REG_PIXEL_TOTAL, {1'($urandom), 15'($urandom_range(TOTAL_FLOOR, 32767))});
			write_reg(REG_STREAM_LENGTH,
				16'($urandom_range(int'(seen_bytes) + 3000, 65535)));
			quiet_mode = c[0];
			queue_random_items(80);
			drain_and_wait(SETTLE_CYCLES);
		end

		// The ending. The model state is settled here, at a header boundary.
		quiet_mode = 1'b1;
		ending = ending_t'($urandom_range(0, 5));
		case (ending)
			END_FULL: begin
				// A run at least as long as the pixels still owed closes the
				// image, clipped where it is longer.
				k = $urandom_range(1, 40);
				write_reg(REG_PIXEL_TOTAL, 16'(int'(drawn_px) + k));
				queue_run($urandom_range(k, 128), PIXEL_W'($urandom));
			end
			END_SHORT_STREAM: begin
				// The run uses the last three stream bytes: pixel plus fill.
				write_reg(REG_STREAM_LENGTH, 16'(int'(seen_bytes) + 3));
				queue_run($urandom_range(1, 128), PIXEL_W'($urandom));
			end
			END_OVERRUN: begin
				// The literal group needs one byte more than the stream has.
				n = $urandom_range(1, 128);
				write_reg(REG_STREAM_LENGTH, 16'(int'(seen_bytes) + 2 * n));
				queue_literal(n);
			end
			END_NOTHING_OWED: begin
				write_reg(REG_PIXEL_TOTAL,
					($urandom_range(0, 1) != 0) ? 16'd0 : 16'(drawn_px));
			end
			END_USED_UP_HEADER: begin
				write_reg(REG_STREAM_LENGTH,
					($urandom_range(0, 1) != 0) ? 16'd0 : seen_bytes);
			end
			default: begin
				// Stop inside a run, then cut the stream where it stands.
				pending_bytes.push_back(RUN_FLAG | 8'($urandom_range(0, 127)));
				if ($urandom_range(0, 1) != 0)
					pending_bytes.push_back(8'($urandom));
				drain_and_wait(SETTLE_CYCLES);
				write_reg(REG_STREAM_LENGTH, seen_bytes);
			end
		endcase

		// Trailing bytes: they trigger the cut-stream endings and must
		// otherwise be absorbed.
		repeat (16) pending_bytes.push_back(8'($urandom));
		drain_and_wait(2 * SETTLE_CYCLES);

		if (mismatches == 0)
			$display("rle_pixel_decoder: match");
		else
			$display("rle_pixel_decoder: mismatch");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("rle_pixel_decoder: mismatch");
		$finish;
	end

endmodule
